### sv/fah_pkg.sv
// shared types and constants for the five-ary min-heap
package fah_pkg;

   localparam int DefCapacity = 64;
   localparam int ValW        = 31;
   localparam int CountW      = 7;
   localparam int Arity       = 5;

   typedef enum logic [1:0] {
      ACT_INSERT  = 2'd0,
      ACT_DEL_MIN = 2'd1,
      ACT_DEL_MAX = 2'd2,
      ACT_QUERY   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_ZERO  = 2'd3
   } status_type;

   // commands from the controller to the datapath
   typedef enum logic [3:0] {
      CMD_NONE   = 4'd0,
      CMD_START  = 4'd1,  // latch request
      CMD_EVAL   = 4'd2,  // evaluate special cases, open an insert hole
      CMD_SCAN   = 4'd3,  // one entry of the min and max scan
      CMD_LAST   = 4'd4,  // read the last entry
      CMD_TAKE   = 4'd5,  // hold the last entry, hole at the target slot
      CMD_UPRD   = 4'd6,  // read the parent of the hole
      CMD_UP     = 4'd7,  // one sift-up compare and move
      CMD_DOWN   = 4'd8,  // one child read or one sift-down move
      CMD_RESULT = 4'd9   // load the result register
   } cmd_type;

   typedef struct packed {
      logic reject;     // request needs no store change
      logic is_insert;
      logic is_del_max;
      logic up_done;
      logic down_end;   // all children of the hole compared
      logic down_stay;  // no child smaller than the held value
      logic scan_done;
      logic target_last;
   } dp_status_type;

endpackage

### sv/fah_ctrl.sv
// controller state machine of the five-ary min-heap
module fah_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_fire,
   input  logic                   rsp_free,
   input  fah_pkg::dp_status_type status,
   output fah_pkg::cmd_type       cmd,
   output logic                   busy
);
   import fah_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_EVAL   = 10'b0000000010,
      S_MSCAN  = 10'b0000000100,
      S_LAST   = 10'b0000001000,
      S_TAKE   = 10'b0000010000,
      S_UPRD   = 10'b0000100000,
      S_UP     = 10'b0001000000,
      S_DOWN   = 10'b0010000000,
      S_SCAN   = 10'b0100000000,
      S_RESULT = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd = CMD_START;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd = CMD_EVAL;
            if (status.reject) state_in = S_SCAN;
            else if (status.is_insert) state_in = S_UPRD;
            else if (status.is_del_max) state_in = S_MSCAN;
            else state_in = S_LAST;
         end
         S_MSCAN: begin
            cmd = CMD_SCAN;
            if (status.scan_done) state_in = S_LAST;
         end
         S_LAST: begin
            cmd = CMD_LAST;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            cmd = CMD_TAKE;
            if (status.target_last) state_in = S_SCAN;
            else state_in = S_UPRD;
         end
         S_UPRD: begin
            cmd = CMD_UPRD;
            state_in = S_UP;
         end
         S_UP: begin
            cmd = CMD_UP;
            if (status.up_done) state_in = status.is_insert ? S_SCAN : S_DOWN;
            else state_in = S_UPRD;
         end
         S_DOWN: begin
            cmd = CMD_DOWN;
            if (status.down_end && status.down_stay) state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd = CMD_SCAN;
            if (status.scan_done) state_in = S_RESULT;
         end
         S_RESULT: begin
            if (rsp_free) begin
               cmd = CMD_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### sv/fah_dp.sv
// datapath of the five-ary min-heap: store, count, sift and scan registers
module fah_dp #(
   parameter int CAPACITY = fah_pkg::DefCapacity
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fah_pkg::cmd_type         cmd,
   input  logic [1:0]               req_action,
   input  logic [fah_pkg::ValW-1:0] req_value,
   output fah_pkg::dp_status_type   status,
   output logic [fah_pkg::ValW-1:0] res_min,
   output logic [fah_pkg::ValW-1:0] res_max,
   output logic [fah_pkg::CountW-1:0] res_count,
   output logic [1:0]               res_status
);
   import fah_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 3; // room for 5*i+6
   localparam int PW = AW + 18;
   // x/5 as (x*52429)>>18, exact well past the largest slot index
   localparam int Recip5     = 52429;
   localparam int RecipShift = 18;

   logic [ValW-1:0] mem [CAPACITY];
   logic [ValW-1:0] rdata_ff;
   logic [AW-1:0]   raddr;
   logic            rd_en;
   logic            wr_en;
   logic [AW-1:0]   waddr;
   logic [ValW-1:0] wdata;

   logic [CW-1:0]   count_ff;
   action_type      act_ff;
   logic [ValW-1:0] val_ff;
   status_type      stat_ff;
   logic [AW-1:0]   pos_ff;     // hole being sifted
   logic [ValW-1:0] cur_ff;     // value held for the hole
   logic [IW-1:0]   idx_ff;     // next child to read
   logic [CW-1:0]   scan_ff;    // next slot to read in a scan
   logic [AW-1:0]   best_ff;
   logic [ValW-1:0] bestv_ff;
   logic            rdv_ff;     // rdata_ff holds the previous read of a scan or child walk
   logic [ValW-1:0] min_ff;
   logic [AW-1:0]   tgt_ff;

   // memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[waddr] <= wdata;
      if (rd_en) rdata_ff <= mem[raddr];
   end

   logic [PW-1:0] par_prod;
   logic [AW-1:0] parent;
   logic [IW-1:0] child0;
   logic [IW-1:0] child_end;
   logic [CW-1:0] cnt_m1;
   logic [CW-1:0] scan_prev;
   logic          child_rd;
   logic          scan_rd;
   logic          up_done;
   logic          down_end;

   assign cnt_m1    = count_ff - CW'(1);
   assign par_prod  = PW'(pos_ff - AW'(1)) * PW'(Recip5);
   assign parent    = AW'(par_prod >> RecipShift);
   assign child0    = IW'(pos_ff) * IW'(Arity) + IW'(1);
   assign child_end = child0 + IW'(Arity);
   assign scan_prev = scan_ff - CW'(1);
   assign child_rd  = (idx_ff < child_end) && (idx_ff < IW'(count_ff));
   assign scan_rd   = (scan_ff < count_ff);
   assign up_done   = (pos_ff == '0) || (rdata_ff <= cur_ff);
   assign down_end  = !child_rd && !rdv_ff;

   logic       reject_c;
   status_type stat_c;
   always_comb begin
      reject_c = 1'b0;
      stat_c   = ST_OK;
      case (act_ff)
         ACT_INSERT: begin
            if (val_ff == '0) begin
               reject_c = 1'b1;
               stat_c   = ST_ZERO;
            end else if (count_ff >= CW'(CAPACITY)) begin
               reject_c = 1'b1;
               stat_c   = ST_FULL;
            end
         end
         ACT_DEL_MIN, ACT_DEL_MAX: begin
            if (count_ff == '0) begin
               reject_c = 1'b1;
               stat_c   = ST_EMPTY;
            end
         end
         default: reject_c = 1'b1;
      endcase
   end

   assign status.reject      = reject_c;
   assign status.is_insert   = (act_ff == ACT_INSERT);
   assign status.is_del_max  = (act_ff == ACT_DEL_MAX);
   assign status.up_done     = up_done;
   assign status.down_end    = down_end;
   assign status.down_stay   = (best_ff == pos_ff);
   assign status.scan_done   = !scan_rd && !rdv_ff;
   assign status.target_last = (tgt_ff == AW'(cnt_m1));

   always_comb begin
      rd_en = 1'b0;
      raddr = '0;
      wr_en = 1'b0;
      waddr = pos_ff;
      wdata = cur_ff;
      case (cmd)
         CMD_SCAN: begin
            rd_en = scan_rd;
            raddr = AW'(scan_ff);
         end
         CMD_LAST: begin
            rd_en = 1'b1;
            raddr = AW'(cnt_m1);
         end
         CMD_UPRD: begin
            rd_en = (pos_ff != '0);
            raddr = parent;
         end
         CMD_UP: begin
            if (!up_done) begin
               wr_en = 1'b1;
               wdata = rdata_ff;
            end else if (act_ff == ACT_INSERT) begin
               wr_en = 1'b1;
            end
         end
         CMD_DOWN: begin
            if (child_rd) begin
               rd_en = 1'b1;
               raddr = AW'(idx_ff);
            end else if (!rdv_ff) begin
               // smallest child moves up into the hole, or the held value settles
               wr_en = 1'b1;
               wdata = (best_ff == pos_ff) ? cur_ff : bestv_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         case (cmd)
            CMD_START: begin
               act_ff  <= action_type'(req_action);
               val_ff  <= req_value;
               scan_ff <= '0;
               rdv_ff  <= 1'b0;
            end
            CMD_EVAL: begin
               stat_ff <= stat_c;
               tgt_ff  <= '0;
               if (!reject_c && act_ff == ACT_INSERT) begin
                  pos_ff   <= AW'(count_ff);
                  cur_ff   <= val_ff;
                  count_ff <= count_ff + CW'(1);
               end
            end
            CMD_SCAN: begin
               if (scan_rd) scan_ff <= scan_ff + CW'(1);
               rdv_ff <= scan_rd;
               if (rdv_ff) begin
                  if (scan_prev == '0) min_ff <= rdata_ff;
                  if (scan_prev == '0 || rdata_ff > bestv_ff) begin
                     bestv_ff <= rdata_ff;
                     tgt_ff   <= AW'(scan_prev);
                  end
               end
            end
            CMD_TAKE: begin
               cur_ff   <= rdata_ff;
               count_ff <= cnt_m1;
               pos_ff   <= tgt_ff;
               scan_ff  <= '0;
               rdv_ff   <= 1'b0;
            end
            CMD_UP: begin
               if (!up_done) pos_ff <= parent;
               else begin
                  idx_ff   <= child0;
                  best_ff  <= pos_ff;
                  bestv_ff <= cur_ff;
                  rdv_ff   <= 1'b0;
               end
            end
            CMD_DOWN: begin
               if (child_rd) idx_ff <= idx_ff + IW'(1);
               rdv_ff <= child_rd;
               if (rdv_ff && rdata_ff < bestv_ff) begin
                  bestv_ff <= rdata_ff;
                  best_ff  <= AW'(idx_ff - IW'(1));
               end
               if (down_end && best_ff != pos_ff) begin
                  pos_ff   <= best_ff;
                  idx_ff   <= IW'(best_ff) * IW'(Arity) + IW'(1);
                  bestv_ff <= cur_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign res_min    = (count_ff == '0) ? '0 : min_ff;
   assign res_max    = (count_ff == '0) ? '0 : bestv_ff;
   assign res_count  = CountW'(count_ff);
   assign res_status = stat_ff;

endmodule

### sv/five_ary_min_heap.sv
// top level of the five-ary min-heap
// One request at a time through a one-write, one-read store that reads one entry a cycle.
// Every request ends with a scan of every entry for the minimum and the maximum,
// which is all that a query or a rejected request does; the count shown is the one
// after the step. An insert first climbs level by level, a parent read and a compare
// per level; a delete first fetches the last entry, then climbs and walks down,
// reading the children at each level; a delete of the maximum begins with its own scan.
// The response register holds a result until taken; the next request is
// accepted from the cycle after the result is loaded.
module five_ary_min_heap #(
   parameter int CAPACITY = fah_pkg::DefCapacity
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // action[1:0], value[32:2], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata   // min_value[30:0], max_value[61:31], count[68:62], status[70:69]
);
   import fah_pkg::*;

   cmd_type       cmd;
   dp_status_type st;
   logic          busy;
   logic [ValW-1:0] rmin, rmax;
   logic [CountW-1:0] rcnt;
   logic [1:0]    rst;
   logic          rsp_valid_ff;
   logic [71:0]   rsp_data_ff;
   logic          req_fire;

   assign req_tready = !busy;
   assign req_fire   = req_tvalid && req_tready;

   fah_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .rsp_free(!rsp_valid_ff || rsp_tready), .status(st), .cmd(cmd), .busy(busy)
   );

   fah_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_action(req_tdata[1:0]), .req_value(req_tdata[32:2]),
      .status(st), .res_min(rmin), .res_max(rmax), .res_count(rcnt), .res_status(rst)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd == CMD_RESULT) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
      if (cmd == CMD_RESULT) rsp_data_ff <= {1'b0, rst, rcnt, rmax, rmin};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("request accepted while busy");
   a_result_once: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_RESULT) |=> rsp_tvalid) else $error("result lost");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("waiting response changed");
`endif

endmodule
